// ----- hw/rtl/twpwf_pkg.sv -----
`default_nettype none

package twpwf_pkg;

  // Field widths
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned PROD_W   = 2 * WORD_W;
  localparam int unsigned SUM_W    = PROD_W + 1;
  localparam int unsigned CASE_W   = 2;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned IN_DATA_W  = 3 * WORD_W;
  localparam int unsigned OUT_DATA_W = 3 * WORD_W;

  // Gains are signed fixed point with this many fraction bits
  localparam int unsigned GAIN_FRAC_BITS = 8;
  // Added to negative products so the shift truncates toward zero
  localparam logic signed [PROD_W-1:0] SCALE_BIAS = PROD_W'((1 << GAIN_FRAC_BITS) - 1);

  // Range bands (exclusive limits)
  localparam logic [WORD_W-1:0] BAND_NEAR_LO = 16'd1000;
  localparam logic [WORD_W-1:0] BAND_MID     = 16'd1900;
  localparam logic [WORD_W-1:0] BAND_FAR_HI  = 16'd2500;

  // Forced left targets
  localparam logic signed [WORD_W-1:0] TARGET_NEAR = 16'sd30;
  localparam logic signed [WORD_W-1:0] TARGET_FAR  = 16'sd5;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_DIST_GAIN     = 3'd2,
    REG_BASE_SPEED    = 3'd3,
    REG_WALL_SETPOINT = 3'd4
  } cfg_reg_t;

  // Source of the left target
  typedef enum logic [CASE_W-1:0] {
    TC_REGULAR = 2'd0,
    TC_NEAR    = 2'd1,
    TC_FAR     = 2'd2
  } turn_case_t;

  // Operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MS_DIST = 3'd0,
    MS_PL   = 3'd1,
    MS_IL   = 3'd2,
    MS_PR   = 3'd3,
    MS_IR   = 3'd4
  } mul_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     scale_en;
    logic     target_en;
    logic     err_en;
    logic     acc_en;
    logic     eff_l_en;
    logic     eff_r_en;
    logic     out_load;
  } dp_cmd_t;

  // Clamp a wide signed sum to 16 bits
  function automatic logic signed [WORD_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[WORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[WORD_W-1:0];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/twpwf_ctrl.sv -----
`default_nettype none

module twpwf_ctrl
  import twpwf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic tick,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DMUL,
    ST_DSCL,
    ST_TGT,
    ST_ERR,
    ST_PLMUL,
    ST_PLSCL,
    ST_ILMUL,
    ST_ILSCL,
    ST_EFFL,
    ST_PRMUL,
    ST_PRSCL,
    ST_IRMUL,
    ST_IRSCL,
    ST_EFFR,
    ST_DONE
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Command decode
  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MS_DIST;
    cmd.load     = accept && tick;
    unique case (state)
      ST_DMUL:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MS_DIST; end
      ST_TGT:   cmd.target_en = 1'b1;
      ST_ERR:   cmd.err_en = 1'b1;
      ST_PLMUL: begin cmd.mul_en = 1'b1; cmd.mul_sel = MS_PL; end
      ST_ILMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_IL;
        cmd.acc_en  = 1'b1;
      end
      ST_EFFL:  cmd.eff_l_en = 1'b1;
      ST_PRMUL: begin cmd.mul_en = 1'b1; cmd.mul_sel = MS_PR; end
      ST_IRMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_IR;
        cmd.acc_en  = 1'b1;
      end
      ST_EFFR:  cmd.eff_r_en = 1'b1;
      ST_DONE:  cmd.out_load = out_free;
      ST_DSCL, ST_PLSCL, ST_ILSCL, ST_PRSCL, ST_IRSCL: cmd.scale_en = 1'b1;
      default:  ;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE:  if (accept && tick) state <= ST_DMUL;
        ST_DMUL:  state <= ST_DSCL;
        ST_DSCL:  state <= ST_TGT;
        ST_TGT:   state <= ST_ERR;
        ST_ERR:   state <= ST_PLMUL;
        ST_PLMUL: state <= ST_PLSCL;
        ST_PLSCL: state <= ST_ILMUL;
        ST_ILMUL: state <= ST_ILSCL;
        ST_ILSCL: state <= ST_EFFL;
        ST_EFFL:  state <= ST_PRMUL;
        ST_PRMUL: state <= ST_PRSCL;
        ST_PRSCL: state <= ST_IRMUL;
        ST_IRMUL: state <= ST_IRSCL;
        ST_IRSCL: state <= ST_EFFR;
        ST_EFFR:  state <= ST_DONE;
        ST_DONE:  if (out_free) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/twpwf_dp.sv -----
`default_nettype none

module twpwf_dp
  import twpwf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [IDX_W-1:0]      cfg_index,
  input  wire logic [WORD_W-1:0]     cfg_data,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire dp_cmd_t               cmd,
  output logic      [OUT_DATA_W-1:0] out_data,
  output logic      [CASE_W-1:0]     out_case
);

  // Configuration
  logic signed [WORD_W-1:0] prop_gain;
  logic signed [WORD_W-1:0] integ_gain;
  logic signed [WORD_W-1:0] dist_gain;
  logic signed [WORD_W-1:0] base_speed;
  logic        [WORD_W-1:0] wall_setpoint;

  // Loop state
  logic        [WORD_W-1:0] last_left_count;
  logic        [WORD_W-1:0] last_right_count;
  logic signed [WORD_W-1:0] left_error_sum;
  logic signed [WORD_W-1:0] right_error_sum;

  // Working registers
  logic signed [WORD_W-1:0] speed_l;
  logic signed [WORD_W-1:0] speed_r;
  logic signed [WORD_W-1:0] dist_err;
  logic signed [WORD_W-1:0] target_l;
  logic signed [WORD_W-1:0] err_l;
  logic signed [WORD_W-1:0] err_r;
  turn_case_t               turn_case;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] scaled;
  logic signed [PROD_W-1:0] acc;
  logic signed [WORD_W-1:0] eff_l;
  logic signed [WORD_W-1:0] eff_r;

  // Result register
  logic signed [WORD_W-1:0] out_left_effort;
  logic signed [WORD_W-1:0] out_right_effort;
  logic signed [WORD_W-1:0] out_left_target;
  turn_case_t               out_turn_case;

  logic [WORD_W-1:0]        left_count;
  logic [WORD_W-1:0]        right_count;
  logic [WORD_W-1:0]        range_reading;
  turn_case_t               case_next;
  logic signed [WORD_W-1:0] mul_a;
  logic signed [WORD_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [WORD_W-1:0] target_next;
  logic signed [WORD_W-1:0] err_l_next;
  logic signed [WORD_W-1:0] err_r_next;
  logic signed [SUM_W-1:0]  eff_sum;

  assign left_count    = in_data[WORD_W-1:0];
  assign right_count   = in_data[2*WORD_W-1:WORD_W];
  assign range_reading = in_data[3*WORD_W-1:2*WORD_W];

  // Band decision on the range reading
  always_comb begin
    if (range_reading > BAND_NEAR_LO && range_reading < BAND_MID) begin
      case_next = TC_NEAR;
    end else if (range_reading > BAND_MID && range_reading < BAND_FAR_HI) begin
      case_next = TC_FAR;
    end else begin
      case_next = TC_REGULAR;
    end
  end

  // Multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      MS_DIST: begin mul_a = dist_gain;  mul_b = dist_err;        end
      MS_PL:   begin mul_a = prop_gain;  mul_b = err_l;           end
      MS_IL:   begin mul_a = integ_gain; mul_b = left_error_sum;  end
      MS_PR:   begin mul_a = prop_gain;  mul_b = err_r;           end
      MS_IR:   begin mul_a = integ_gain; mul_b = right_error_sum; end
      default: begin mul_a = '0;         mul_b = '0;              end
    endcase
  end

  // Truncate toward zero: bias negative products before the shift
  assign prod_adj = prod + (prod[PROD_W-1] ? SCALE_BIAS : '0);

  always_comb begin
    unique case (turn_case)
      TC_NEAR: target_next = TARGET_NEAR;
      TC_FAR:  target_next = TARGET_FAR;
      default: target_next = sat16(SUM_W'(scaled) + SUM_W'(base_speed));
    endcase
  end

  assign err_l_next = target_l - speed_l;
  assign err_r_next = base_speed - speed_r;
  assign eff_sum    = SUM_W'(acc) + SUM_W'(scaled);

  // Configuration and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain        <= '0;
      integ_gain       <= '0;
      dist_gain        <= '0;
      base_speed       <= '0;
      wall_setpoint    <= '0;
      last_left_count  <= '0;
      last_right_count <= '0;
      left_error_sum   <= '0;
      right_error_sum  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PROP_GAIN:     prop_gain     <= cfg_data;
          REG_INTEG_GAIN:    integ_gain    <= cfg_data;
          REG_DIST_GAIN:     dist_gain     <= cfg_data;
          REG_BASE_SPEED:    base_speed    <= cfg_data;
          REG_WALL_SETPOINT: wall_setpoint <= cfg_data;
          default:           ;
        endcase
      end
      if (cmd.load) begin
        last_left_count  <= left_count;
        last_right_count <= right_count;
      end
      if (cmd.err_en) begin
        left_error_sum  <= left_error_sum + err_l_next;
        right_error_sum <= right_error_sum + err_r_next;
      end
    end
  end

  // Arithmetic datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      speed_l   <= left_count - last_left_count;
      speed_r   <= right_count - last_right_count;
      dist_err  <= wall_setpoint - range_reading;
      turn_case <= case_next;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.scale_en) begin
      scaled <= prod_adj >>> GAIN_FRAC_BITS;
    end
    if (cmd.acc_en) begin
      acc <= scaled;
    end
    if (cmd.target_en) begin
      target_l <= target_next;
    end
    if (cmd.err_en) begin
      err_l <= err_l_next;
      err_r <= err_r_next;
    end
    if (cmd.eff_l_en) begin
      eff_l <= sat16(eff_sum);
    end
    if (cmd.eff_r_en) begin
      eff_r <= sat16(eff_sum);
    end
    if (cmd.out_load) begin
      out_left_effort  <= eff_l;
      out_right_effort <= eff_r;
      out_left_target  <= target_l;
      out_turn_case    <= turn_case;
    end
  end

  assign out_data = {out_left_target, out_right_effort, out_left_effort};
  assign out_case = out_turn_case;

endmodule

`default_nettype wire

// ----- hw/rtl/two_wheel_pi_wall_follower_core.sv -----
`default_nettype none

// Channel   Direction  Contents
// s_axis    in         tuser: tick_ready; tdata: left_count, right_count, range_reading
// m_axis    out        tuser: turn_case; tdata: left_effort, right_effort, left_target
// cfg       in         cfg_we, cfg_index (register), cfg_data (16-bit value)
//
// A request with tick_ready set runs a control step through the states ST_DMUL to ST_DONE;
// the input stays closed until the step ends and the core is back in ST_IDLE.
// One multiplier is shared by five products, each followed by a truncation state.
// A request with tick_ready clear is taken while idle and gives no result.
// rst (synchronous) clears the configuration registers, encoder history and error sums.
// A result waits in the output register; a new request is taken meanwhile and its
// result is held in the last step until the output register frees up.

module two_wheel_pi_wall_follower_core
  import twpwf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [IDX_W-1:0]      cfg_index,
  input  wire logic [WORD_W-1:0]     cfg_data,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // left_count, right_count, range_reading
  input  wire logic                  s_axis_tuser,  // tick_ready
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,  // left_effort, right_effort, left_target
  output logic      [CASE_W-1:0]     m_axis_tuser   // turn_case
);

  dp_cmd_t cmd;

  twpwf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .tick      (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  twpwf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .out_data  (m_axis_tdata),
    .out_case  (m_axis_tuser)
  );

  // A control step keeps the input closed on the following cycle
  a_busy_after_step: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
    else $error("input taken while a control step runs");

  // Reported case is always a defined code
  a_case_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == TC_REGULAR || m_axis_tuser == TC_NEAR ||
                       m_axis_tuser == TC_FAR))
    else $error("undefined turn case on output");

  // Forced bands carry their fixed left target
  a_near_target: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == TC_NEAR) |->
      (m_axis_tdata[3*WORD_W-1:2*WORD_W] == TARGET_NEAR))
    else $error("near band result with wrong left target");

  a_far_target: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == TC_FAR) |->
      (m_axis_tdata[3*WORD_W-1:2*WORD_W] == TARGET_FAR))
    else $error("far band result with wrong left target");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
module testbench;
  import twpwf_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned MAX_IDLE        = 13;
  localparam int unsigned PHASE_COUNT     = 9;
  localparam int unsigned ITEMS_PER_PHASE = 205;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam logic [IDX_W-1:0] SPARE_INDEX_LAST = IDX_W'((1 << IDX_W) - 1);
  localparam longint WORD_MAX = 32767;
  localparam longint WORD_MIN = -32768;

  // One result as it leaves the master side
  typedef struct {
    logic signed [WORD_W-1:0] left_effort;
    logic signed [WORD_W-1:0] right_effort;
    logic signed [WORD_W-1:0] left_target;
    turn_case_t               turn_case;
  } wheel_result_t;

  // Tracks register and loop state, predicts efforts, checks results in order
  class effort_scoreboard;
    logic signed [WORD_W-1:0] prop_gain, integ_gain, dist_gain, base_speed;
    logic        [WORD_W-1:0] wall_setpoint;
    logic        [WORD_W-1:0] prev_left, prev_right;
    logic signed [WORD_W-1:0] left_sum, right_sum;
    wheel_result_t            expected_efforts[$];
    int unsigned              mismatches;

    function new();
      prop_gain     = '0;
      integ_gain    = '0;
      dist_gain     = '0;
      base_speed    = '0;
      wall_setpoint = '0;
      prev_left     = '0;
      prev_right    = '0;
      left_sum      = '0;
      right_sum     = '0;
      mismatches    = 0;
    endfunction

    function int unsigned pending();
      return expected_efforts.size();
    endfunction

    // Indexes past the last register are dropped
    function void write_reg(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] value);
      case (idx)
        REG_PROP_GAIN:     prop_gain     = value;
        REG_INTEG_GAIN:    integ_gain    = value;
        REG_DIST_GAIN:     dist_gain     = value;
        REG_BASE_SPEED:    base_speed    = value;
        REG_WALL_SETPOINT: wall_setpoint = value;
        default: ;
      endcase
    endfunction

    // Fixed point product, division truncates toward zero
    function longint scaled(longint gain, longint x);
      return (gain * x) / (longint'(1) << GAIN_FRAC_BITS);
    endfunction

    function logic signed [WORD_W-1:0] clamp16(longint v);
      if (v > WORD_MAX) return WORD_MAX[WORD_W-1:0];
      if (v < WORD_MIN) return WORD_MIN[WORD_W-1:0];
      return v[WORD_W-1:0];
    endfunction

    function logic signed [WORD_W-1:0] effort(logic signed [WORD_W-1:0] err,
                                              logic signed [WORD_W-1:0] acc);
      return clamp16(scaled(prop_gain, err) + scaled(integ_gain, acc));
    endfunction

    // One control step per accepted request with tick_ready set
    function void note_request(logic tick, logic [IN_DATA_W-1:0] data);
      logic        [WORD_W-1:0] left_cnt, right_cnt, range_val;
      logic signed [WORD_W-1:0] left_speed, right_speed, dist_err, left_err, right_err;
      wheel_result_t            res;
      if (tick) begin
        left_cnt   = data[WORD_W-1:0];
        right_cnt  = data[2*WORD_W-1:WORD_W];
        range_val  = data[3*WORD_W-1:2*WORD_W];
        left_speed  = left_cnt - prev_left;
        right_speed = right_cnt - prev_right;
        prev_left  = left_cnt;
        prev_right = right_cnt;
        // forced bands, edges fall to the regular correction
        if (range_val > BAND_NEAR_LO && range_val < BAND_MID) begin
          res.turn_case   = TC_NEAR;
          res.left_target = TARGET_NEAR;
        end else if (range_val > BAND_MID && range_val < BAND_FAR_HI) begin
          res.turn_case   = TC_FAR;
          res.left_target = TARGET_FAR;
        end else begin
          res.turn_case   = TC_REGULAR;
          dist_err        = wall_setpoint - range_val;
          res.left_target = clamp16(scaled(dist_gain, dist_err) + base_speed);
        end
        // PI steps, errors and sums wrap at 16 bits
        left_err  = res.left_target - left_speed;
        right_err = base_speed - right_speed;
        left_sum  = left_sum + left_err;
        right_sum = right_sum + right_err;
        res.left_effort  = effort(left_err, left_sum);
        res.right_effort = effort(right_err, right_sum);
        expected_efforts.push_back(res);
      end
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want,
                                logic [WORD_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch on %s: expected %0d actual %0d", name, $signed(want),
                   $signed(got));
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic [CASE_W-1:0] tc);
      wheel_result_t want;
      if (expected_efforts.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: tdata %h tuser %0d", data, tc);
      end else begin
        want = expected_efforts.pop_front();
        compare_field("left_effort", want.left_effort, data[WORD_W-1:0]);
        compare_field("right_effort", want.right_effort, data[2*WORD_W-1:WORD_W]);
        compare_field("left_target", want.left_target, data[3*WORD_W-1:2*WORD_W]);
        compare_field("turn_case", WORD_W'(want.turn_case), WORD_W'(tc));
      end
    endfunction
  endclass

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_we        = 1'b0;
  logic [IDX_W-1:0]      cfg_index     = '0;
  logic [WORD_W-1:0]     cfg_data      = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // left_count, right_count, range_reading
  logic                  s_axis_tuser  = 1'b0; // tick_ready
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // left_effort, right_effort, left_target
  logic [CASE_W-1:0]     m_axis_tuser;        // turn_case

  effort_scoreboard      sb;
  logic [WORD_W-1:0]     walk_left, walk_right;
  bit                    send_burst = 1'b0;
  bit                    recv_burst = 1'b0;
  int unsigned           cycle_count;

  two_wheel_pi_wall_follower_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Sample both handshakes on the edge; results first, then new requests
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
    end
  end

  // Result side: random stall before each result, with bursts of no stall
  initial begin
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // Offer one request after a random gap, return on the accepting edge
  task automatic send_request(input logic tick, input logic [WORD_W-1:0] lc,
                              input logic [WORD_W-1:0] rc,
                              input logic [WORD_W-1:0] range_val);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= tick;
    s_axis_tdata  <= {range_val, rc, lc};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Hold off new requests until every result is out and the core has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  // Register set per phase: fixed sets first, extremes among them, then random ones
  task automatic apply_settings(input int unsigned phase);
    logic [WORD_W-1:0] pg, ig, dg, bs, ws;
    case (phase)
      0: begin
        pg = 16'h0180; ig = 16'h0020; dg = 16'h0080; bs = 16'd40; ws = 16'd3000;
      end
      1: begin
        pg = 16'h7fff; ig = 16'h7fff; dg = 16'h7fff; bs = 16'h7fff; ws = 16'hffff;
      end
      2: begin
        pg = 16'h8000; ig = 16'h8000; dg = 16'h8000; bs = 16'h8000; ws = 16'h0000;
      end
      3: begin
        pg = 16'h7fff; ig = 16'h8000; dg = 16'h8000; bs = 16'h7fff; ws = BAND_MID;
      end
      4: begin
        pg = 16'h0000; ig = 16'h0000; dg = 16'h0000; bs = 16'h0000; ws = 16'hffff;
      end
      default: begin
        if (phase % 2 == 1) begin
          pg = WORD_W'($urandom_range(0, 1024));
          ig = WORD_W'($urandom_range(0, 96));
          dg = WORD_W'(int'($urandom_range(0, 512)) - 256);
          bs = WORD_W'(int'($urandom_range(0, 120)) - 40);
          ws = WORD_W'($urandom_range(500, 4000));
        end else begin
          pg = WORD_W'($urandom);
          ig = WORD_W'($urandom);
          dg = WORD_W'($urandom);
          bs = WORD_W'($urandom);
          ws = WORD_W'($urandom);
        end
      end
    endcase
    program_reg(REG_PROP_GAIN, pg);
    program_reg(REG_INTEG_GAIN, ig);
    program_reg(REG_DIST_GAIN, dg);
    program_reg(REG_BASE_SPEED, bs);
    program_reg(REG_WALL_SETPOINT, ws);
    // write to an unused index, must be dropped
    program_reg(IDX_W'($urandom_range(int'(REG_WALL_SETPOINT) + 1, int'(SPARE_INDEX_LAST))),
                WORD_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic              tick;
    logic [WORD_W-1:0] lc, rc, range_val, band_lim;
    int unsigned       pick;
    sb         = new();
    walk_left  = '0;
    walk_right = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: band edges, range extremes, idle requests, encoder wrap
    apply_settings(0);
    send_request(1'b1, 16'd0, 16'd0, 16'd3000);
    send_request(1'b1, 16'd40, 16'd40, 16'd0);
    send_request(1'b1, 16'd80, 16'd80, 16'hffff);
    send_request(1'b1, 16'd120, 16'd120, BAND_NEAR_LO);
    send_request(1'b1, 16'd160, 16'd160, BAND_NEAR_LO + 16'd1);
    send_request(1'b1, 16'd200, 16'd200, BAND_MID - 16'd1);
    send_request(1'b1, 16'd240, 16'd240, BAND_MID);
    send_request(1'b1, 16'd280, 16'd280, BAND_MID + 16'd1);
    send_request(1'b1, 16'd320, 16'd320, BAND_FAR_HI - 16'd1);
    send_request(1'b1, 16'd360, 16'd360, BAND_FAR_HI);
    // idle requests leave the encoder history and sums alone
    send_request(1'b0, 16'hffff, 16'hffff, 16'hffff);
    send_request(1'b0, 16'h1234, 16'h8765, 16'd1500);
    send_request(1'b1, 16'h7fff, 16'h8000, 16'd2000);
    send_request(1'b1, 16'h8000, 16'h7fff, 16'd2000);
    send_request(1'b1, 16'h0000, 16'hffff, 16'd4000);
    send_request(1'b1, 16'hffff, 16'h0000, BAND_FAR_HI);
    send_request(1'b1, 16'h7fff, 16'h7fff, 16'h8000);
    send_request(1'b1, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_request(1'b1, 16'h0000, 16'h0000, 16'd1);
    wait_idle();

    // Further phases, fixed extremes then random, one register set each
    for (int unsigned phase = 1; phase <= PHASE_COUNT; phase++) begin
      apply_settings(phase);
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        tick = ($urandom_range(0, 6) != 0);
        // mostly smooth encoder motion, some jumps anywhere
        if ($urandom_range(0, 9) < 8) begin
          lc = walk_left + WORD_W'(int'($urandom_range(0, 200)) - 100);
          rc = walk_right + WORD_W'(int'($urandom_range(0, 200)) - 100);
        end else begin
          lc = WORD_W'($urandom);
          rc = WORD_W'($urandom);
        end
        if (tick) begin
          walk_left  = lc;
          walk_right = rc;
        end
        pick = $urandom_range(0, 9);
        case (pick)
          0, 1, 2: range_val = WORD_W'($urandom_range(1001, 1899));
          3, 4:    range_val = WORD_W'($urandom_range(1901, 2499));
          5: begin
            case ($urandom_range(0, 2))
              0:       band_lim = BAND_NEAR_LO;
              1:       band_lim = BAND_MID;
              default: band_lim = BAND_FAR_HI;
            endcase
            range_val = band_lim + WORD_W'(int'($urandom_range(0, 2)) - 1);
          end
          6, 7:    range_val = WORD_W'($urandom_range(0, 4000));
          default: range_val = WORD_W'($urandom);
        endcase
        send_request(tick, lc, rc, range_val);
        // drain the pipeline once mid-phase
        if (n == ITEMS_PER_PHASE / 2) wait_idle();
      end
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/twpwf_pkg.sv
hw/rtl/twpwf_ctrl.sv
hw/rtl/twpwf_dp.sv
hw/rtl/two_wheel_pi_wall_follower_core.sv
verif/testbench.sv
